>>> rtl/core/m4inv_pkg.sv
`default_nettype none
package m4inv_pkg;

  localparam int DATA_W = 32;
  localparam int IDX_W = 4;
  localparam int NUM_ELEM = 16;
  localparam int FRAC_BITS_DEF = 16;
  localparam int QUEUE_DEPTH_DEF = 4;

  // intermediate store: 2x2 minors of rows 2/3, of rows 0/1, then the adjugate
  localparam int WORK_W = 100;
  localparam int WORK_N = 28;
  localparam int WIDX_W = 5;
  localparam int C_BASE = 0;
  localparam int S_BASE = 6;
  localparam int ADJ_BASE = 12;

  // multiply unit: element times one limb of a wide operand
  localparam int LIMB_W = 36;
  localparam int PROD_W = DATA_W + LIMB_W;
  localparam int ACC_W = 136;
  localparam logic [1:0] LIMB_TOP = 2'd2;

  localparam int NUM_OPS = 76;
  localparam int OP_W = 7;

  // quotient bits kept by the divider, top bit flags overflow
  localparam int QUO_W = 34;
  localparam logic [DATA_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] SAT_MIN = 32'h8000_0000;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic [IDX_W-1:0] index;
    logic last;
  } elem_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic [IDX_W-1:0] a_idx;
    logic b_elem;
    logic [WIDX_W-1:0] b_idx;
    logic neg;
    logic first;
    logic last;
    logic to_det;
    logic [WIDX_W-1:0] dest;
  } op_t;

  typedef op_t [NUM_OPS-1:0] prog_t;

  function automatic int pair_idx(input int p, input int q);
    if (p == 0) return q - 1;
    if (p == 1) return q + 1;
    return 5;
  endfunction

  function automatic op_t mk_op(input int a, input int be, input int b, input int ng,
                                input int fs, input int ls, input int td, input int dst);
    op_t o;
    o.a_idx = IDX_W'(a);
    o.b_elem = be[0];
    o.b_idx = WIDX_W'(b);
    o.neg = ng[0];
    o.first = fs[0];
    o.last = ls[0];
    o.to_det = td[0];
    o.dest = WIDX_W'(dst);
    return o;
  endfunction

  // micro-program: 2x2 minors, 3x3 cofactors, then the determinant
  function automatic prog_t build_prog();
    prog_t pr;
    int n, i, j, k, p, q, r, t, rowx, base, o1, o2, ng;
    int cols [3];
    pr = '0;
    n = 0;
    for (p = 0; p < 4; p++) begin
      for (q = p + 1; q < 4; q++) begin
        for (r = 0; r < 2; r++) begin
          base = (r == 1) ? S_BASE : C_BASE;
          rowx = (r == 1) ? 0 : 2;
          pr[n] = mk_op(rowx * 4 + p, 1, (rowx + 1) * 4 + q, 0, 1, 0, 0, base + pair_idx(p, q));
          n++;
          pr[n] = mk_op(rowx * 4 + q, 1, (rowx + 1) * 4 + p, 1, 0, 1, 0, base + pair_idx(p, q));
          n++;
        end
      end
    end
    for (i = 0; i < 4; i++) begin
      for (j = 0; j < 4; j++) begin
        t = 0;
        for (p = 0; p < 4; p++) begin
          if (p != i) begin
            cols[t] = p;
            t++;
          end
        end
        case (j)
          0: rowx = 1;
          1: rowx = 0;
          2: rowx = 3;
          default: rowx = 2;
        endcase
        base = (j < 2) ? C_BASE : S_BASE;
        for (k = 0; k < 3; k++) begin
          o1 = (k == 0) ? cols[1] : cols[0];
          o2 = (k == 2) ? cols[1] : cols[2];
          ng = ((k == 1) ? 1 : 0) ^ ((i + j) & 1);
          pr[n] = mk_op(rowx * 4 + cols[k], 0, base + pair_idx(o1, o2), ng,
                        (k == 0) ? 1 : 0, (k == 2) ? 1 : 0, 0, ADJ_BASE + i * 4 + j);
          n++;
        end
      end
    end
    for (j = 0; j < 4; j++) begin
      pr[n] = mk_op(j, 0, ADJ_BASE + j * 4, 0, (j == 0) ? 1 : 0, (j == 3) ? 1 : 0, 1, 0);
      n++;
    end
    return pr;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/m4inv_if.sv
`default_nettype none
interface m4inv_in_if;
  import m4inv_pkg::*;
  logic valid;
  logic ready;
  logic signed [DATA_W-1:0] element_value;
  modport source(output valid, output element_value, input ready);
  modport sink(input valid, input element_value, output ready);
endinterface

interface m4inv_out_if;
  import m4inv_pkg::*;
  logic valid;
  logic ready;
  logic signed [DATA_W-1:0] inverse_value;
  logic [IDX_W-1:0] element_index;
  logic singular;
  logic last_element;
  modport source(output valid, output inverse_value, output element_index,
                 output singular, output last_element, input ready);
  modport sink(input valid, input inverse_value, input element_index,
               input singular, input last_element, output ready);
endinterface
`default_nettype wire

>>> rtl/core/m4inv_front.sv
`default_nettype none
module m4inv_front (
  input  wire logic              clk,
  input  wire logic              rst,
  m4inv_in_if.sink               elem_ch,
  input  wire m4inv_pkg::q_stat_t q_stat,
  output logic                   q_push,
  output m4inv_pkg::elem_t       q_wdata
);
  import m4inv_pkg::*;

  logic [IDX_W-1:0] load_count;

  assign elem_ch.ready = !q_stat.full;
  assign q_push = elem_ch.valid && !q_stat.full;

  // tag each element with its position and mark the end of a matrix
  assign q_wdata.value = elem_ch.element_value;
  assign q_wdata.index = load_count;
  assign q_wdata.last = (load_count == IDX_W'(NUM_ELEM - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      load_count <= '0;
    end else if (q_push) begin
      load_count <= load_count + 1'b1;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/m4inv_queue.sv
`default_nettype none
module m4inv_queue #(
  parameter int DEPTH = m4inv_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire m4inv_pkg::elem_t  wdata,
  input  wire logic              pop,
  output m4inv_pkg::elem_t       rdata,
  output m4inv_pkg::q_stat_t     stat
);
  import m4inv_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  elem_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign rdata = mem[rd_ptr];
  assign stat.full = (count == CNT_W'(DEPTH));
  assign stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/m4inv_div.sv
`default_nettype none
module m4inv_div #(
  parameter int FRAC_BITS = m4inv_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  start,
  input  wire logic signed [m4inv_pkg::WORK_W-1:0]   adj,
  input  wire logic signed [m4inv_pkg::ACC_W-1:0]    det,
  output logic                                       done,
  output logic [m4inv_pkg::DATA_W-1:0]               quo
);
  import m4inv_pkg::*;

  localparam int NUM_W = WORK_W + 2 * FRAC_BITS;
  localparam int DIV_W = (ACC_W + QUO_W > NUM_W) ? ACC_W + QUO_W : NUM_W;
  localparam int CNT_W = $clog2(QUO_W + 1);

  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] dsh;
  logic [QUO_W-1:0] q;
  logic [CNT_W-1:0] cnt;
  logic busy;
  logic neg;
  logic [WORK_W-1:0] adj_mag;
  logic [ACC_W-1:0] det_mag;
  logic [DIV_W:0] diff;
  logic ge;
  logic ovf;
  logic [QUO_W-2:0] mag;

  assign adj_mag = adj[WORK_W-1] ? WORK_W'(-adj) : WORK_W'(adj);
  assign det_mag = det[ACC_W-1] ? ACC_W'(-det) : ACC_W'(det);
  assign diff = {1'b0, rem} - {1'b0, dsh};
  assign ge = !diff[DIV_W];

  // restoring division, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= DIV_W'(adj_mag) << (2 * FRAC_BITS);
      dsh <= DIV_W'(det_mag) << (QUO_W - 1);
      q <= '0;
      neg <= adj[WORK_W-1] ^ det[ACC_W-1];
    end else if (busy) begin
      if (ge) begin
        rem <= diff[DIV_W-1:0];
      end
      q <= {q[QUO_W-2:0], ge};
      dsh <= dsh >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == CNT_W'(1));
      if (start) begin
        busy <= 1'b1;
        cnt <= CNT_W'(QUO_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // saturate to the signed output range
  assign ovf = q[QUO_W-1];
  assign mag = q[QUO_W-2:0];

  always_comb begin
    if (!neg) begin
      quo = (ovf || mag > (QUO_W-1)'(SAT_MAX)) ? SAT_MAX : mag[DATA_W-1:0];
    end else begin
      quo = (ovf || mag > (QUO_W-1)'(SAT_MIN)) ? SAT_MIN : DATA_W'(-mag[DATA_W-1:0]);
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/m4inv_back.sv
`default_nettype none
module m4inv_back #(
  parameter int FRAC_BITS = m4inv_pkg::FRAC_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire m4inv_pkg::elem_t  q_data,
  input  wire m4inv_pkg::q_stat_t q_stat,
  output logic                   q_pop,
  m4inv_out_if.source            result_ch
);
  import m4inv_pkg::*;

  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_MAC   = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_FETCH = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_WAIT  = 3'd5;
  localparam logic [2:0] S_PUT   = 3'd6;

  localparam prog_t PROG = build_prog();

  typedef struct packed {
    logic b_elem;
    logic [1:0] limb;
    logic neg;
    logic first;
    logic last;
    logic to_det;
    logic [WIDX_W-1:0] dest;
  } ctl_t;

  logic [2:0] state;
  logic [OP_W-1:0] op_ptr;
  logic [1:0] limb;
  logic [IDX_W-1:0] idx;
  op_t op;
  logic issue;
  logic op_done;
  ctl_t ctl0, ctl1, ctl2;
  logic v1, v2;

  logic signed [DATA_W-1:0] mstore [NUM_ELEM];
  logic signed [WORK_W-1:0] work [WORK_N];
  logic [WIDX_W-1:0] work_raddr;
  logic signed [DATA_W-1:0] a_q;
  logic signed [DATA_W-1:0] be_q;
  logic signed [WORK_W-1:0] bw_q;

  logic signed [LIMB_W-1:0] limb_val;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0] term;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] acc_next;
  logic signed [ACC_W-1:0] det;
  logic det_zero;

  logic div_start;
  logic div_done;
  logic [DATA_W-1:0] div_quo;
  logic [DATA_W-1:0] res;
  logic out_load;

  assign op = PROG[op_ptr];
  assign issue = (state == S_MAC);
  assign op_done = op.b_elem ? (limb == 2'd0) : (limb == LIMB_TOP);
  assign q_pop = (state == S_LOAD) && !q_stat.empty;
  assign det_zero = (det == '0);
  assign div_start = (state == S_DIV) && !det_zero;
  assign out_load = (state == S_PUT) && (!result_ch.valid || result_ch.ready);
  assign work_raddr = issue ? op.b_idx : WIDX_W'(ADJ_BASE) + WIDX_W'(idx);

  always_comb begin
    ctl0.b_elem = op.b_elem;
    ctl0.limb = limb;
    ctl0.neg = op.neg;
    ctl0.first = op.first && (limb == 2'd0);
    ctl0.last = op.last && op_done;
    ctl0.to_det = op.to_det;
    ctl0.dest = op.dest;
  end

  // operand fetch: matrix store has two read ports, work store one
  always_ff @(posedge clk) begin
    if (q_pop) begin
      mstore[q_data.index] <= q_data.value;
    end
    a_q <= mstore[op.a_idx];
    be_q <= mstore[op.b_idx[IDX_W-1:0]];
    bw_q <= work[work_raddr];
    if (v2 && ctl2.last && !ctl2.to_det) begin
      work[ctl2.dest] <= acc_next[WORK_W-1:0];
    end
  end

  // limb of the wide operand, low limbs unsigned, top limb signed
  always_comb begin
    if (ctl1.b_elem) begin
      limb_val = LIMB_W'(be_q);
    end else begin
      case (ctl1.limb)
        2'd0: limb_val = $signed({{(LIMB_W - DATA_W){1'b0}}, bw_q[DATA_W-1:0]});
        2'd1: limb_val = $signed({{(LIMB_W - DATA_W){1'b0}}, bw_q[2*DATA_W-1:DATA_W]});
        default: limb_val = $signed(bw_q[WORK_W-1:2*DATA_W]);
      endcase
    end
  end

  always_comb begin
    case (ctl2.limb)
      2'd0: term = ACC_W'(prod);
      2'd1: term = ACC_W'(prod) << DATA_W;
      default: term = ACC_W'(prod) << (2 * DATA_W);
    endcase
    acc_next = (ctl2.first ? ACC_W'(0) : acc) + (ctl2.neg ? -term : term);
  end

  always_ff @(posedge clk) begin
    ctl1 <= ctl0;
    ctl2 <= ctl1;
    prod <= PROD_W'(a_q) * PROD_W'(limb_val);
    if (v2) begin
      acc <= acc_next;
      if (ctl2.last && ctl2.to_det) begin
        det <= acc_next;
      end
    end
  end

  m4inv_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .adj  (bw_q),
    .det  (det),
    .done (div_done),
    .quo  (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      op_ptr <= '0;
      limb <= '0;
      idx <= '0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      res <= '0;
    end else begin
      v1 <= issue;
      v2 <= v1;
      case (state)
        S_LOAD: begin
          if (q_pop && q_data.last) begin
            state <= S_MAC;
            op_ptr <= '0;
            limb <= '0;
          end
        end
        S_MAC: begin
          if (op_done) begin
            limb <= '0;
            if (op_ptr == OP_W'(NUM_OPS - 1)) begin
              state <= S_DRAIN;
            end else begin
              op_ptr <= op_ptr + 1'b1;
            end
          end else begin
            limb <= limb + 1'b1;
          end
        end
        S_DRAIN: begin
          if (!v1 && !v2) begin
            state <= S_FETCH;
            idx <= '0;
          end
        end
        S_FETCH: state <= S_DIV;
        S_DIV: begin
          if (det_zero) begin
            res <= '0;
            state <= S_PUT;
          end else begin
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (div_done) begin
            res <= div_quo;
            state <= S_PUT;
          end
        end
        S_PUT: begin
          if (out_load) begin
            idx <= idx + 1'b1;
            state <= (idx == IDX_W'(NUM_ELEM - 1)) ? S_LOAD : S_FETCH;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_ch.valid <= 1'b0;
    end else if (out_load) begin
      result_ch.valid <= 1'b1;
    end else if (result_ch.ready) begin
      result_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result_ch.inverse_value <= res;
      result_ch.element_index <= idx;
      result_ch.singular <= det_zero;
      result_ch.last_element <= (idx == IDX_W'(NUM_ELEM - 1));
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/matrix4x4_inverse_core.sv
// 4x4 matrix inverse by the adjugate method, signed fixed point with
// FRAC_BITS fraction bits (Q16.16 by default)
// elem_ch: sixteen beats per matrix, row-major, one element per beat
// result_ch: sixteen beats per matrix, row-major, with element_index,
//   singular (determinant exactly zero, value forced to zero) and
//   last_element on the sixteenth beat
// the front counts elements and pushes them into a small queue; the back
// drains the queue into its matrix store, then runs a shared multiply unit
// (one element times one 32/36-bit limb a cycle) through a fixed op list:
// twelve 2x2 minors, sixteen cofactors and the determinant
// each entry is then divided by a restoring divider, one quotient bit a
// cycle, one entry at a time
// the queue keeps taking input beats while the back works, up to its depth
// a stalled receiver holds the output register and pauses the back
// reset clears the element count, the queue and the sequencer; the matrix
// store needs no clearing since a matrix is complete before it is used
`default_nettype none
module matrix4x4_inverse_core #(
  parameter int FRAC_BITS = m4inv_pkg::FRAC_BITS_DEF,
  parameter int QUEUE_DEPTH = m4inv_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst,
  m4inv_in_if.sink       elem_ch,
  m4inv_out_if.source    result_ch
);
  import m4inv_pkg::*;

  // queue between the front and the back
  q_stat_t q_stat;
  logic q_push;
  logic q_pop;
  elem_t q_wdata;
  elem_t q_rdata;

  // front: count and tag incoming elements
  m4inv_front u_front (
    .clk    (clk),
    .rst    (rst),
    .elem_ch(elem_ch),
    .q_stat (q_stat),
    .q_push (q_push),
    .q_wdata(q_wdata)
  );

  m4inv_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .wdata(q_wdata),
    .pop  (q_pop),
    .rdata(q_rdata),
    .stat (q_stat)
  );

  // back: minors, determinant, division and the output register
  m4inv_back #(
    .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_data   (q_rdata),
    .q_stat   (q_stat),
    .q_pop    (q_pop),
    .result_ch(result_ch)
  );

  // results of a matrix leave in index order
  a_index_order: assert property (@(posedge clk) disable iff (rst)
    result_ch.valid && result_ch.ready |=> !result_ch.valid ||
      result_ch.element_index == IDX_W'($past(result_ch.element_index) + 1'b1))
    else $error("result index out of order");

  // a singular matrix gives an all-zero result
  a_singular_zero: assert property (@(posedge clk) disable iff (rst)
    result_ch.valid && result_ch.singular |-> result_ch.inverse_value == '0)
    else $error("singular result with nonzero value");

  // the front never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_stat.full)
    else $error("queue overflow");

endmodule
`default_nettype wire
